>>> rtl/core/gha_pkg.sv
`default_nettype none

package gha_pkg;

  // Handle layout: version above slot index.
  localparam int HANDLE_W  = 32;
  localparam int VERSION_W = 12;
  localparam int INDEX_W   = 20;
  localparam int COUNT_W   = 11;
  localparam int DEAD_W    = 13;
  localparam int REQ_W     = 2;
  localparam int STAT_W    = 2;

  localparam logic [DEAD_W-1:0] DEAD_VERSION_RESET = 13'd4095;

  // Register word index of dead_version on the configuration port.
  localparam logic REG_DEAD_VERSION = 1'b0;

  // Request codes; any other code behaves as a check.
  localparam logic [REQ_W-1:0] REQ_CREATE  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DESTROY = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CHECK   = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOT_LIVE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic exec;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_stall;
  } dp_status_t;

endpackage

`default_nettype wire

>>> rtl/core/gha_ctrl.sv
`default_nettype none

module gha_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire gha_pkg::dp_status_t stat,
  output gha_pkg::ctl_cmd_t      cmd
);

  gha_pkg::state_t state;
  gha_pkg::state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gha_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands. The slot entry is read on the accepting edge
  // and written back when the result is loaded into the output register.
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    cmd        = '0;
    case (state)
      gha_pkg::ST_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
        if (s_tvalid) begin
          state_next = gha_pkg::ST_EXEC;
        end
      end
      gha_pkg::ST_EXEC: begin
        if (!stat.out_stall) begin
          cmd.exec   = 1'b1;
          state_next = gha_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = gha_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/gha_dp.sv
`default_nettype none

module gha_dp #(
  parameter int CAPACITY = 1024
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire gha_pkg::ctl_cmd_t                 cmd,
  output gha_pkg::dp_status_t                    stat,
  input  wire logic [gha_pkg::REQ_W-1:0]         req_type,
  input  wire logic [gha_pkg::HANDLE_W-1:0]      entity_handle,
  input  wire logic [gha_pkg::DEAD_W-1:0]        dead_version,
  input  wire logic                              out_ready,
  output logic                                   out_valid,
  output logic [gha_pkg::HANDLE_W-1:0]           result_handle,
  output logic [gha_pkg::STAT_W-1:0]             status,
  output logic [gha_pkg::COUNT_W-1:0]            live_count
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  // Slot table: live slots hold their handle, free slots hold the next
  // version and the link to the next free slot.
  logic [gha_pkg::HANDLE_W-1:0] slot_mem [CAPACITY];

  logic [gha_pkg::REQ_W-1:0]    req;
  logic [gha_pkg::HANDLE_W-1:0] hdl;
  logic [gha_pkg::HANDLE_W-1:0] rdata;
  logic [IW-1:0]                rd_addr;

  logic [CW-1:0] slots_used;
  logic [CW-1:0] free_head;
  logic [CW-1:0] live_total;
  logic [CW-1:0] slots_used_next;
  logic [CW-1:0] free_head_next;
  logic [CW-1:0] live_total_next;

  logic                          wr_en;
  logic [IW-1:0]                 wr_addr;
  logic [gha_pkg::HANDLE_W-1:0]  wr_data;
  logic [gha_pkg::HANDLE_W-1:0]  res;
  logic [gha_pkg::STAT_W-1:0]    res_stat;

  logic [gha_pkg::INDEX_W-1:0]   h_idx;
  logic                          list_empty;
  logic                          table_full;
  logic                          head_in_table;
  logic                          is_live;
  logic [gha_pkg::DEAD_W-1:0]    ver_bump;
  logic [gha_pkg::VERSION_W-1:0] ver_new;

  // Create reads the free-list head, the other requests read their slot.
  assign rd_addr = (req_type == gha_pkg::REQ_CREATE) ? free_head[IW-1:0]
                                                     : entity_handle[IW-1:0];

  // Request latch and registered table read on the accepting edge.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req   <= req_type;
      hdl   <= entity_handle;
      rdata <= slot_mem[rd_addr];
    end
  end

  // Table write-back.
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      slot_mem[wr_addr] <= wr_data;
    end
  end

  // Request evaluation against the entry just read.
  always_comb begin
    h_idx         = hdl[gha_pkg::INDEX_W-1:0];
    list_empty    = (free_head == slots_used);
    table_full    = (slots_used == CW'(CAPACITY));
    head_in_table = (free_head < CW'(CAPACITY));
    is_live       = ({1'b0, h_idx} < (gha_pkg::INDEX_W + 1)'(slots_used)) && (rdata == hdl);

    // Bump the version; the dead value folds to zero, then keep 12 bits.
    ver_bump = {1'b0, hdl[gha_pkg::HANDLE_W-1:gha_pkg::INDEX_W]} + 13'd1;
    if (ver_bump == dead_version) begin
      ver_bump = '0;
    end
    ver_new = ver_bump[gha_pkg::VERSION_W-1:0];

    res             = hdl;
    res_stat        = gha_pkg::STAT_OK;
    wr_en           = 1'b0;
    wr_addr         = hdl[IW-1:0];
    wr_data         = rdata;
    slots_used_next = slots_used;
    free_head_next  = free_head;
    live_total_next = live_total;

    case (req)
      gha_pkg::REQ_CREATE: begin
        if (list_empty) begin
          if (table_full) begin
            res      = '0;
            res_stat = gha_pkg::STAT_FULL;
          end else begin
            // Append a fresh slot at version zero.
            res             = {{gha_pkg::VERSION_W{1'b0}}, gha_pkg::INDEX_W'(slots_used)};
            wr_en           = 1'b1;
            wr_addr         = slots_used[IW-1:0];
            wr_data         = res;
            slots_used_next = CW'(slots_used + 1'b1);
            free_head_next  = CW'(slots_used + 1'b1);
            live_total_next = CW'(live_total + 1'b1);
          end
        end else if (head_in_table) begin
          // Pop the free list; the entry carries the version to hand out.
          res = {rdata[gha_pkg::HANDLE_W-1:gha_pkg::INDEX_W],
                 gha_pkg::INDEX_W'(free_head)};
          wr_en           = 1'b1;
          wr_addr         = free_head[IW-1:0];
          wr_data         = res;
          free_head_next  = CW'(rdata[gha_pkg::INDEX_W-1:0]);
          live_total_next = CW'(live_total + 1'b1);
        end else begin
          res      = '0;
          res_stat = gha_pkg::STAT_FULL;
        end
      end
      gha_pkg::REQ_DESTROY: begin
        if (!is_live) begin
          res_stat = gha_pkg::STAT_NOT_LIVE;
        end else begin
          // Push the slot with its bumped version.
          wr_en           = 1'b1;
          wr_data         = {ver_new, gha_pkg::INDEX_W'(free_head)};
          free_head_next  = CW'(h_idx);
          live_total_next = CW'(live_total - 1'b1);
        end
      end
      default: begin
        res_stat = is_live ? gha_pkg::STAT_OK : gha_pkg::STAT_NOT_LIVE;
      end
    endcase
  end

  // Allocator bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      slots_used <= '0;
      free_head  <= '0;
      live_total <= '0;
    end else if (cmd.exec) begin
      slots_used <= slots_used_next;
      free_head  <= free_head_next;
      live_total <= live_total_next;
    end
  end

  // Output register; it holds a result until the beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      result_handle <= res;
      status        <= res_stat;
      live_count    <= gha_pkg::COUNT_W'(live_total_next);
    end
  end

  assign stat.out_stall = out_valid && !out_ready;

endmodule

`default_nettype wire

>>> rtl/core/generational_handle_allocator_core.sv
// The block takes no new request until the previous one has executed: the
// slot-table entry is read on the accepting edge and written back when the
// result is loaded into the output register, which waits while the output
// stalls, and the free-list head then feeds the next request.
// Reset clears the slot count, free-list head, live count and handshake
// state and sets dead_version to 4095; the slot table itself is not cleared.
`default_nettype none

module generational_handle_allocator_core #(
  parameter int CAPACITY = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Request stream.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // req_type[1:0], entity_handle[33:2], zero pad
  // Result stream.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // result_handle[31:0], status[33:32],
                                      // live_count[44:34], zero pad
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  gha_pkg::ctl_cmd_t   cmd;
  gha_pkg::dp_status_t stat;

  logic [gha_pkg::DEAD_W-1:0]   dead_version;
  logic [gha_pkg::HANDLE_W-1:0] result_handle;
  logic [gha_pkg::STAT_W-1:0]   status;
  logic [gha_pkg::COUNT_W-1:0]  live_count;
  logic                         reg_sel;

  // Configuration register.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == gha_pkg::REG_DEAD_VERSION);

  always_ff @(posedge clk) begin
    if (rst) begin
      dead_version <= gha_pkg::DEAD_VERSION_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      dead_version <= pwdata[gha_pkg::DEAD_W-1:0];
    end
  end

  assign prdata = reg_sel ? {{(32 - gha_pkg::DEAD_W){1'b0}}, dead_version} : 32'd0;

  gha_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  gha_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .req_type      (s_tdata[1:0]),
    .entity_handle (s_tdata[33:2]),
    .dead_version  (dead_version),
    .out_ready     (m_tready),
    .out_valid     (m_tvalid),
    .result_handle (result_handle),
    .status        (status),
    .live_count    (live_count)
  );

  assign m_tdata = {3'b000, live_count, status, result_handle};

  // A request is not taken while the previous one is still being executed.
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request accepted during execution");

  // With room in the output register while the request executes, its result is loaded there.
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) ##1 (!m_tvalid || m_tready) |=> m_tvalid)
    else $error("result missing after accepted request");

  // A full table always reports a zero handle.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[33:32] == gha_pkg::STAT_FULL)) |-> (m_tdata[31:0] == 32'd0))
    else $error("full status with nonzero handle");

endmodule

`default_nettype wire

>>> bench/generational_handle_allocator_core_tb.sv
`timescale 1ns / 100ps

module generational_handle_allocator_core_tb;
  import gha_pkg::*;

  localparam int SLOT_COUNT = 1024;
  localparam int LIMIT_CYCLES = 4_000_000;

  // The spare request code is handled as a check.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [REQ_W-1:0]    req;
  } request_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [STAT_W-1:0]   status;
    logic [COUNT_W-1:0]  count;
  } result_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // req_type[1:0], entity_handle[33:2], zero pad
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;        // result_handle[31:0], status[33:32], live_count[44:34]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  generational_handle_allocator_core #(
    .CAPACITY(SLOT_COUNT)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // Shadow copy of the allocator state.
  logic [HANDLE_W-1:0] slot_shadow [0:SLOT_COUNT-1];
  int                  slots_used = 0;
  int                  free_head = 0;
  int                  live_total = 0;
  logic [DEAD_W-1:0]   dead_version = DEAD_VERSION_RESET;

  request_t            request_queue [$];
  result_t             pending_results [$];
  logic [HANDLE_W-1:0] live_handles [$];
  logic [HANDLE_W-1:0] retired_handles [$];

  int       mismatch_count = 0;
  int       cycle_count = 0;
  int       in_gap = 0;
  int       steady_in = 0;
  int       out_gap = 0;
  int       steady_out = 0;
  request_t next_beat;
  result_t  got_result;
  result_t  want_result;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic logic handle_is_live(input logic [HANDLE_W-1:0] h);
    int idx;
    idx = int'(h[INDEX_W-1:0]);
    if (idx >= slots_used) return 1'b0;
    return slot_shadow[idx] == h;
  endfunction

  // Applies one request to the shadow state and queues the result it yields.
  function automatic void predict_allocation(input logic [REQ_W-1:0] req,
                                             input logic [HANDLE_W-1:0] h);
    result_t             r;
    logic [HANDLE_W-1:0] entry;
    logic [DEAD_W-1:0]   ver;
    int                  idx;
    int                  pos;
    r.handle = h;
    r.status = STAT_OK;
    idx = int'(h[INDEX_W-1:0]);
    if (req == REQ_CREATE) begin
      if (free_head == slots_used) begin
        if (slots_used >= SLOT_COUNT) begin
          r.handle = '0;
          r.status = STAT_FULL;
        end else begin
          r.handle = {{VERSION_W{1'b0}}, INDEX_W'(slots_used)};
          slot_shadow[slots_used] = r.handle;
          slots_used++;
          free_head = slots_used;
          live_total++;
          live_handles.insert(live_handles.size(), r.handle);
        end
      end else begin
        entry = slot_shadow[free_head];
        r.handle = {entry[HANDLE_W-1:INDEX_W], INDEX_W'(free_head)};
        slot_shadow[free_head] = r.handle;
        free_head = int'(entry[INDEX_W-1:0]);
        live_total++;
        live_handles.insert(live_handles.size(), r.handle);
      end
    end else if (req == REQ_DESTROY) begin
      if (!handle_is_live(h)) begin
        r.status = STAT_NOT_LIVE;
      end else begin
        ver = {1'b0, h[HANDLE_W-1:INDEX_W]} + 1'b1;
        if (ver == dead_version) ver = '0;
        slot_shadow[idx] = {ver[VERSION_W-1:0], INDEX_W'(free_head)};
        free_head = idx;
        live_total--;
        pos = -1;
        for (int i = 0; i < live_handles.size(); i++) begin
          if (live_handles[i] == h) pos = i;
        end
        if (pos >= 0) live_handles.delete(pos);
        retired_handles.insert(retired_handles.size(), h);
        if (retired_handles.size() > 64) void'(retired_handles.pop_front());
      end
    end else begin
      r.status = handle_is_live(h) ? STAT_OK : STAT_NOT_LIVE;
    end
    r.count = COUNT_W'(live_total);
    pending_results.insert(pending_results.size(), r);
  endfunction

  // Chooses a handle: often a live one, else a retired, a re-versioned or a random one.
  function automatic logic [HANDLE_W-1:0] pick_handle(input int live_pct);
    int                  roll;
    logic [HANDLE_W-1:0] h;
    roll = $urandom_range(0, 99);
    h = $urandom;
    if (roll < live_pct && live_handles.size() > 0) begin
      if ($urandom_range(0, 1) == 0) h = live_handles[$];
      else h = live_handles[$urandom_range(0, live_handles.size() - 1)];
    end else if (roll < live_pct + 15 && retired_handles.size() > 0) begin
      h = retired_handles[$urandom_range(0, retired_handles.size() - 1)];
    end else if (roll < live_pct + 25 && live_handles.size() > 0) begin
      h = live_handles[$urandom_range(0, live_handles.size() - 1)];
      h[HANDLE_W-1:INDEX_W] = VERSION_W'($urandom);
    end
    return h;
  endfunction

  task automatic push_request(input logic [REQ_W-1:0] r, input logic [HANDLE_W-1:0] h);
    request_queue.insert(request_queue.size(), {h, r});
  endtask

  // Waits until every request is sent and every result is back.
  task automatic settle(input int extra);
    @(negedge clk);
    while (request_queue.size() > 0 || s_tvalid || pending_results.size() > 0)
      @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_dead_version(input logic [DEAD_W-1:0] value);
    logic [31:0] word;
    word = $urandom;
    word[DEAD_W-1:0] = value;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_DEAD_VERSION, 2'b00};
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    dead_version = value;
  endtask

  task automatic add_random(input int create_pct, input int destroy_pct, input int live_pct);
    int                  roll;
    logic [REQ_W-1:0]    r;
    logic [HANDLE_W-1:0] h;
    while (request_queue.size() >= 2) @(negedge clk);
    roll = $urandom_range(0, 99);
    h = pick_handle(live_pct);
    if (roll < create_pct) begin
      r = REQ_CREATE;
      h = $urandom;
    end else if (roll < create_pct + destroy_pct) begin
      r = REQ_DESTROY;
    end else if ($urandom_range(0, 4) == 0) begin
      r = REQ_UNUSED;
    end else begin
      r = REQ_CHECK;
    end
    push_request(r, h);
  endtask

  // Destroys and recreates the newest slot over and over to advance its version.
  task automatic sweep_versions(input int pairs);
    if (live_handles.size() == 0) begin
      push_request(REQ_CREATE, $urandom);
      settle(0);
    end
    repeat (pairs) begin
      push_request(REQ_DESTROY, live_handles[$]);
      push_request(REQ_CREATE, $urandom);
      settle(0);
    end
  endtask

  // Request driver with random gaps between beats.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      in_gap <= 0;
      steady_in <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (in_gap > 0) begin
        s_tvalid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (request_queue.size() > 0) begin
        next_beat = request_queue.pop_front();
        s_tdata <= {6'd0, next_beat.handle, next_beat.req};
        s_tvalid <= 1'b1;
        if (steady_in > 0) begin
          steady_in <= steady_in - 1;
          in_gap <= 0;
        end else begin
          in_gap <= gap_len();
          if ($urandom_range(0, 15) == 0) steady_in <= $urandom_range(16, 64);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: predicts on each accepted request beat and checks each result beat.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      out_gap <= 0;
      steady_out <= 0;
    end else begin
      if (s_tvalid && s_tready) predict_allocation(s_tdata[1:0], s_tdata[33:2]);

      if (m_tvalid && m_tready) begin
        got_result = {m_tdata[31:0], m_tdata[33:32], m_tdata[44:34]};
        if (pending_results.size() == 0) begin
          $error("result beat with no request outstanding: tdata=%h", m_tdata);
          mismatch_count++;
        end else begin
          want_result = pending_results.pop_front();
          if (got_result.handle !== want_result.handle) begin
            $error("result_handle: expected %h, got %h", want_result.handle, got_result.handle);
            mismatch_count++;
          end
          if (got_result.status !== want_result.status) begin
            $error("status: expected %0d, got %0d", want_result.status, got_result.status);
            mismatch_count++;
          end
          if (got_result.count !== want_result.count) begin
            $error("live_count: expected %0d, got %0d", want_result.count, got_result.count);
            mismatch_count++;
          end
        end
      end

      // Receiver stalls at random, with stretches of steady readiness.
      if (out_gap > 0) begin
        m_tready <= 1'b0;
        out_gap <= out_gap - 1;
      end else if (steady_out == 0 && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        out_gap <= gap_len();
      end else begin
        m_tready <= 1'b1;
        if (steady_out > 0) steady_out <= steady_out - 1;
        else if ($urandom_range(0, 31) == 0) steady_out <= $urandom_range(16, 64);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("** generational_handle_allocator_core: FAILED **");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    write_dead_version(13'd4095);

    // Directed: empty table, extreme handles, stale versions, reuse and the spare code.
    push_request(REQ_CHECK, 32'h0000_0000);
    push_request(REQ_DESTROY, 32'hFFFF_FFFF);
    push_request(REQ_CREATE, 32'hFFFF_FFFF);
    push_request(REQ_CREATE, 32'h0000_0000);
    push_request(REQ_CHECK, 32'h0000_0001);
    push_request(REQ_CHECK, 32'h0010_0001);
    push_request(REQ_CHECK, 32'h0000_0002);
    push_request(REQ_DESTROY, 32'h0000_0001);
    push_request(REQ_DESTROY, 32'h0000_0001);
    push_request(REQ_UNUSED, 32'h0010_0001);
    push_request(REQ_CREATE, 32'h0000_0000);
    push_request(REQ_UNUSED, 32'h0010_0001);
    push_request(REQ_CHECK, 32'hFFF0_0001);
    push_request(REQ_DESTROY, 32'h0000_0000);
    push_request(REQ_DESTROY, 32'h0010_0001);
    push_request(REQ_CREATE, 32'h0000_0000);
    push_request(REQ_CREATE, 32'h0000_0000);
    push_request(REQ_CREATE, 32'h0000_0000);
    settle(8);

    // Dead version set to 2, then a destroy of a stale handle, a create and a check.
    write_dead_version(13'd2);
    push_request(REQ_DESTROY, 32'h0010_0001);
    push_request(REQ_CREATE, 32'h0000_0000);
    push_request(REQ_CHECK, 32'h0000_0001);
    settle(8);

    write_dead_version(13'd4095);
    repeat (160) add_random(40, 35, 60);
    settle(8);

    write_dead_version(13'd3);
    repeat (160) add_random(35, 40, 60);
    settle(8);

    // Recycle one slot repeatedly under dead versions that never match.
    write_dead_version(13'd0);
    sweep_versions(20);
    settle(8);
    write_dead_version(13'd4096);
    sweep_versions(20);
    settle(8);

    write_dead_version(13'd1);
    repeat (80) add_random(40, 35, 60);
    settle(20);

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("** generational_handle_allocator_core: PASSED **");
    end else begin
      $display("** generational_handle_allocator_core: FAILED **");
    end
    $finish;
  end

endmodule
